@@ rtl/bdq_pkg.sv @@
package bdq_pkg;

   localparam int DEPTH  = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int OCC_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;

   localparam int REQ_W = 40;
   localparam int RSP_W = 104;

   localparam logic [1:0] MODE_PUSH_BACK  = 2'd0;
   localparam logic [1:0] MODE_PUSH_FRONT = 2'd1;
   localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
   localparam logic [1:0] MODE_POP_BACK   = 2'd3;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic read;
      logic refill;
      logic load_rsp;
   } bdq_cmd_type;

   typedef struct packed {
      logic need_refill;
      logic rsp_free;
   } bdq_status_type;

   function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] i);
      return (i == ADDR_W'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] ring_prev(input logic [ADDR_W-1:0] i);
      return (i == '0) ? ADDR_W'(DEPTH - 1) : i - 1'b1;
   endfunction

endpackage

@@ rtl/bdq_ctrl.sv @@
module bdq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  bdq_pkg::bdq_status_type status,
   output bdq_pkg::bdq_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_REFILL,
      ST_RESULT
   } state_type;

   state_type state_ff;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:   cmd.load_req = req_tvalid;
         ST_EXEC:   cmd.exec     = 1'b1;
         ST_READ:   cmd.read     = 1'b1;
         ST_REFILL: cmd.refill   = 1'b1;
         ST_RESULT: cmd.load_rsp = status.rsp_free;
         default:   cmd          = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               // a pop that leaves words behind must fetch the new end word
               state_ff <= status.need_refill ? ST_READ : ST_RESULT;
            end
            ST_READ:   state_ff <= ST_REFILL;
            ST_REFILL: state_ff <= ST_RESULT;
            ST_RESULT: begin
               if (status.rsp_free) state_ff <= ST_IDLE;
            end
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

@@ rtl/bdq_dp.sv @@
module bdq_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [bdq_pkg::REQ_W-1:0]    req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [bdq_pkg::RSP_W-1:0]    rsp_tdata,
   input  bdq_pkg::bdq_cmd_type         cmd,
   output bdq_pkg::bdq_status_type      status
);

   localparam int AW = bdq_pkg::ADDR_W;
   localparam int OW = bdq_pkg::OCC_W;
   localparam int WW = bdq_pkg::WORD_W;

   logic [WW-1:0] mem [bdq_pkg::DEPTH];

   logic [1:0]    mode_ff;
   logic [WW-1:0] value_ff;
   logic [AW-1:0] head_ff, tail_ff;
   logic [OW-1:0] occ_ff;
   logic [WW-1:0] front_ff, back_ff;
   logic [WW-1:0] popped_ff;
   logic          pop_valid_ff, dropped_ff;
   logic [WW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          rsp_valid_ff;
   logic [bdq_pkg::RSP_W-1:0] rsp_data_ff;

   logic          is_push, is_full, is_empty;
   logic          wr_en;
   logic [AW-1:0] wr_addr;

   assign is_push  = (mode_ff == bdq_pkg::MODE_PUSH_BACK) ||
                     (mode_ff == bdq_pkg::MODE_PUSH_FRONT);
   assign is_full  = (occ_ff == OW'(bdq_pkg::DEPTH));
   assign is_empty = (occ_ff == '0);

   assign status.need_refill = !is_push && (occ_ff > OW'(1));
   assign status.rsp_free    = !rsp_valid_ff || rsp_tready;

   assign wr_en   = cmd.exec && is_push && !is_full;
   assign wr_addr = (mode_ff == bdq_pkg::MODE_PUSH_BACK) ? tail_ff
                                                         : bdq_pkg::ring_prev(head_ff);
   assign rd_addr = (mode_ff == bdq_pkg::MODE_POP_FRONT) ? head_ff
                                                         : bdq_pkg::ring_prev(tail_ff);

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= value_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.read) rd_data_ff <= mem[rd_addr];
   end

   // payload, end-word cache and response data
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff  <= req_tdata[1:0];
         value_ff <= req_tdata[WW+1:2];
      end
      if (cmd.exec) begin
         popped_ff    <= '0;
         pop_valid_ff <= 1'b0;
         dropped_ff   <= 1'b0;
         case (mode_ff)
            bdq_pkg::MODE_PUSH_BACK: begin
               if (is_full) begin
                  dropped_ff <= 1'b1;
               end else begin
                  back_ff <= value_ff;
                  if (is_empty) front_ff <= value_ff;
               end
            end
            bdq_pkg::MODE_PUSH_FRONT: begin
               if (is_full) begin
                  dropped_ff <= 1'b1;
               end else begin
                  front_ff <= value_ff;
                  if (is_empty) back_ff <= value_ff;
               end
            end
            bdq_pkg::MODE_POP_FRONT: begin
               if (!is_empty) begin
                  popped_ff    <= front_ff;
                  pop_valid_ff <= 1'b1;
               end
            end
            bdq_pkg::MODE_POP_BACK: begin
               if (!is_empty) begin
                  popped_ff    <= back_ff;
                  pop_valid_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (cmd.refill) begin
         if (mode_ff == bdq_pkg::MODE_POP_FRONT) front_ff <= rd_data_ff;
         else                                    back_ff  <= rd_data_ff;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= {4'b0000, dropped_ff, is_full, is_empty,
                         is_empty ? '0 : back_ff,
                         is_empty ? '0 : front_ff,
                         pop_valid_ff, popped_ff};
      end
   end

   // ring pointers, occupancy and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.exec) begin
            case (mode_ff)
               bdq_pkg::MODE_PUSH_BACK: begin
                  if (!is_full) begin
                     tail_ff <= bdq_pkg::ring_next(tail_ff);
                     occ_ff  <= occ_ff + 1'b1;
                  end
               end
               bdq_pkg::MODE_PUSH_FRONT: begin
                  if (!is_full) begin
                     head_ff <= bdq_pkg::ring_prev(head_ff);
                     occ_ff  <= occ_ff + 1'b1;
                  end
               end
               bdq_pkg::MODE_POP_FRONT: begin
                  if (!is_empty) begin
                     head_ff <= bdq_pkg::ring_next(head_ff);
                     occ_ff  <= occ_ff - 1'b1;
                  end
               end
               bdq_pkg::MODE_POP_BACK: begin
                  if (!is_empty) begin
                     tail_ff <= bdq_pkg::ring_prev(tail_ff);
                     occ_ff  <= occ_ff - 1'b1;
                  end
               end
               default: ;
            endcase
         end
         if (cmd.load_rsp)     rsp_valid_ff <= 1'b1;
         else if (rsp_tready)  rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/bounded_deque.sv @@
// Sequence: for a push, or a pop that leaves the deque empty or finds it empty, the request
// passes the EXEC and RESULT states before rsp_tvalid rises. For a pop that leaves words
// behind it passes EXEC, READ, REFILL and RESULT, as one registered read of the ring store
// refetches the new end word. RESULT waits until the response register is free; the
// controller handles one request at a time, the response register frees the input side.
// Reset (synchronous, active high) empties the deque and drops a pending response;
// store contents are not cleared, only occupied entries are ever read.
module bounded_deque (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [bdq_pkg::REQ_W-1:0] req_tdata,  // mode[1:0], value[33:2], zero pad
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // popped[31:0], pop_valid[32], front_value[64:33], back_value[96:65],
   // is_empty[97], is_full[98], push_dropped[99], zero pad
   output logic [bdq_pkg::RSP_W-1:0] rsp_tdata
);

   bdq_pkg::bdq_cmd_type    cmd;
   bdq_pkg::bdq_status_type status;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bdq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
